/* rtl/bsc_pkg.sv */
`timescale 1ns / 1ps

package bsc_pkg;

    localparam int TOTAL_BITS_DEF = 1024;
    localparam int WORD_BITS      = 32;
    localparam int WORD_LSB       = 5;

    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 10;
    localparam int LEN_W    = 11;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 2;

    localparam logic [SIZE_W-1:0] BITS_IN_USE_RST = 11'd1024;

    typedef enum logic [MODE_W-1:0] {
        M_SET      = 3'd0,
        M_CLR      = 3'd1,
        M_TEST     = 3'd2,
        M_FIND_CLR = 3'd3,
        M_FIND_SET = 3'd4,
        M_SET_RUN  = 3'd5,
        M_CLR_RUN  = 3'd6,
        M_CLR_ALL  = 3'd7
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic check;
        logic run;
        logic clr;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_all;
        logic early;
        logic fin;
        logic clr_last;
    } t_stat;

endpackage

/* rtl/bitmap_set_clear_find_engine.sv */
`timescale 1ns / 1ps

// Bitmap store of TOTAL_BITS bits with set, clear, test, find-lowest, run and
// clear-all commands. A command is taken when start is high and busy is low;
// every command gives exactly one result, shown with o_done for one cycle, and
// the receiver cannot stall it (the result ports hold until the cycle after
// the next command is taken). The store lives in a one-read, one-write RAM of
// 32-bit words, and every command that is not settled at its check walks it
// one word per cycle: set, clear, test, a run or a search read each word they
// touch, and clear all writes every word to zero. After reset the block
// sweeps the RAM to zero with busy high; bits_in_use writes are taken at any
// time. A new command may be given in the cycle that shows o_done.

module bitmap_set_clear_find_engine #(
    parameter int TOTAL_BITS = bsc_pkg::TOTAL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bsc_pkg::MODE_W-1:0]    i_mode,
    input  logic [bsc_pkg::INDEX_W-1:0]   i_bit_index,
    input  logic [bsc_pkg::LEN_W-1:0]     i_run_length,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsc_pkg::SIZE_W-1:0]    i_cfg_data,
    output logic                          o_done,
    output logic [bsc_pkg::STATUS_W-1:0]  o_status,
    output logic [bsc_pkg::INDEX_W-1:0]   o_found_index,
    output logic                          o_bit_value
);

    bsc_pkg::t_cmd  cmd;
    bsc_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    bsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bsc_dpath #(
        .TOTAL_BITS (TOTAL_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (i_mode),
        .i_bit_index   (i_bit_index),
        .i_run_length  (i_run_length),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_bit_value   (o_bit_value)
    );

`ifndef SYNTHESIS
    // a result is only ever shown once the controller is back in idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted command did not make the block busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != bsc_pkg::ST_OK)) |->
            (!o_bit_value && (o_found_index == '0)))
        else $error("failed command reports data");
`endif

endmodule

/* rtl/bsc_ram.sv */
`timescale 1ns / 1ps

module bsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bsc_ctrl.sv */
`timescale 1ns / 1ps

module bsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bsc_pkg::t_stat i_stat,
    output bsc_pkg::t_cmd  o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    typedef enum logic [2:0] {
        S_RST_CLR,
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_CLR
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_RST_CLR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.clr_all) begin
                    n_state = S_CLR;
                end else if (i_stat.early) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.fin) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_CLR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        o_cmd.latch = (r_state == S_IDLE) && i_start;
        o_cmd.check = (r_state == S_CHECK);
        o_cmd.run   = (r_state == S_RUN);
        o_cmd.clr   = (r_state == S_RST_CLR) || (r_state == S_CLR);
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

/* rtl/bsc_dpath.sv */
`timescale 1ns / 1ps

module bsc_dpath #(
    parameter int TOTAL_BITS = bsc_pkg::TOTAL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsc_pkg::t_cmd                 i_cmd,
    output bsc_pkg::t_stat                o_stat,
    input  logic [bsc_pkg::MODE_W-1:0]    i_mode,
    input  logic [bsc_pkg::INDEX_W-1:0]   i_bit_index,
    input  logic [bsc_pkg::LEN_W-1:0]     i_run_length,
    input  logic                          i_cfg_valid,
    input  logic [bsc_pkg::SIZE_W-1:0]    i_cfg_data,
    output logic [bsc_pkg::STATUS_W-1:0]  o_status,
    output logic [bsc_pkg::INDEX_W-1:0]   o_found_index,
    output logic                          o_bit_value
);

    localparam int WB       = bsc_pkg::WORD_BITS;
    localparam int LSB      = bsc_pkg::WORD_LSB;
    localparam int SW       = bsc_pkg::SIZE_W;
    localparam int WORDS    = (TOTAL_BITS + WB - 1) / WB;
    localparam int WAW      = (WORDS > 1) ? $clog2(WORDS) : 1;
    // wide enough for the word of any bit below the used size
    localparam int CNTW     = (WAW > SW - LSB) ? WAW : SW - LSB;
    localparam int SIZE_CAP = (TOTAL_BITS < 2047) ? TOTAL_BITS : 2047;

    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
    localparam logic [WB-1:0]  ONES      = '1;

    bsc_pkg::t_mode              r_mode;
    logic [bsc_pkg::INDEX_W-1:0] r_idx;
    logic [bsc_pkg::LEN_W-1:0]   r_len;
    logic [SW-1:0]               r_cfg;
    logic [SW-1:0]               r_lo;
    logic [SW-1:0]               r_hi;
    logic [CNTW-1:0]             r_rcnt;
    logic [CNTW-1:0]             r_dcnt;
    logic                        r_issue;
    logic                        r_dv;
    logic [WAW-1:0]              r_ccnt;
    bsc_pkg::t_status            r_status;
    logic [bsc_pkg::INDEX_W-1:0] r_found;
    logic                        r_bit;

    // check stage
    logic [SW-1:0]     size;
    logic [SW-1:0]     idx_ext;
    logic [SW:0]       run_end;
    logic              chk_early;
    bsc_pkg::t_status  chk_status;
    logic [SW-1:0]     chk_lo;
    logic [SW-1:0]     chk_hi;

    // run stage
    logic [WB-1:0]     rdata;
    logic [WB-1:0]     wword;
    logic [WB-1:0]     mask;
    logic [WB-1:0]     hitv;
    logic [CNTW-1:0]   lo_w;
    logic [CNTW-1:0]   hi_w;
    logic [LSB-1:0]    lo_off;
    logic [LSB-1:0]    hi_off;
    logic [LSB-1:0]    pos;
    logic              hit;
    logic              is_write;
    logic              is_test;
    logic              set_val;
    logic              find_set;
    logic              last_data;
    logic              fin;
    logic              clr_last;

    logic              ram_we;
    logic [WAW-1:0]    ram_waddr;
    logic [WB-1:0]     ram_wdata;
    logic              ram_re;

    assign size    = (r_cfg < SW'(SIZE_CAP)) ? r_cfg : SW'(SIZE_CAP);
    assign idx_ext = SW'(r_idx);
    assign run_end = (SW+1)'(r_idx) + (SW+1)'(r_len);

    always_comb begin
        chk_early  = 1'b0;
        chk_status = bsc_pkg::ST_OK;
        chk_lo     = idx_ext;
        chk_hi     = idx_ext;
        case (r_mode)
            bsc_pkg::M_SET, bsc_pkg::M_CLR: begin
                if (idx_ext >= size) begin
                    chk_early  = 1'b1;
                    chk_status = bsc_pkg::ST_INVALID;
                end
            end
            bsc_pkg::M_TEST: begin
                if (idx_ext >= size) begin
                    chk_early = 1'b1;
                end
            end
            bsc_pkg::M_FIND_CLR, bsc_pkg::M_FIND_SET: begin
                chk_lo = '0;
                chk_hi = size - 1'b1;
                if (size == '0) begin
                    chk_early  = 1'b1;
                    chk_status = bsc_pkg::ST_NOT_FOUND;
                end
            end
            bsc_pkg::M_SET_RUN, bsc_pkg::M_CLR_RUN: begin
                chk_hi = SW'(run_end - 1'b1);
                if (run_end > (SW+1)'(size)) begin
                    chk_early  = 1'b1;
                    chk_status = bsc_pkg::ST_INVALID;
                end else if (r_len == '0) begin
                    chk_early = 1'b1;
                end
            end
            default: begin
                chk_early = 1'b0;
            end
        endcase
    end

    assign is_write = (r_mode == bsc_pkg::M_SET) || (r_mode == bsc_pkg::M_CLR) ||
                      (r_mode == bsc_pkg::M_SET_RUN) || (r_mode == bsc_pkg::M_CLR_RUN);
    assign is_test  = (r_mode == bsc_pkg::M_TEST);
    assign set_val  = (r_mode == bsc_pkg::M_SET) || (r_mode == bsc_pkg::M_SET_RUN);
    assign find_set = (r_mode == bsc_pkg::M_FIND_SET);

    assign lo_w   = CNTW'(r_lo[SW-1:LSB]);
    assign hi_w   = CNTW'(r_hi[SW-1:LSB]);
    assign lo_off = (r_dcnt == lo_w) ? r_lo[LSB-1:0] : '0;
    assign hi_off = (r_dcnt == hi_w) ? r_hi[LSB-1:0] : '1;
    // bits of this word that lie within [lo, hi]
    assign mask   = (ONES << lo_off) & (ONES >> (LSB'(WB - 1) - hi_off));
    assign hitv   = (find_set ? rdata : ~rdata) & mask;
    assign hit    = |hitv;
    assign wword  = set_val ? (rdata | mask) : (rdata & ~mask);

    always_comb begin
        pos = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (hitv[i]) begin
                pos = LSB'(i);
            end
        end
    end

    assign last_data = (r_dcnt == hi_w);
    assign fin = i_cmd.run && r_dv && (is_test || last_data || (!is_write && hit));
    assign clr_last = (r_ccnt == LAST_WORD);

    always_comb begin
        o_stat.clr_all  = (r_mode == bsc_pkg::M_CLR_ALL);
        o_stat.early    = chk_early;
        o_stat.fin      = fin;
        o_stat.clr_last = clr_last;
    end

    assign ram_we    = i_cmd.clr || (i_cmd.run && r_dv && is_write);
    assign ram_waddr = i_cmd.clr ? r_ccnt : WAW'(r_dcnt);
    assign ram_wdata = i_cmd.clr ? '0 : wword;
    assign ram_re    = i_cmd.run && r_issue;

    bsc_ram #(
        .WIDTH (WB),
        .DEPTH (WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (WAW'(r_rcnt)),
        .o_rdata (rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= bsc_pkg::BITS_IN_USE_RST;
            r_issue <= 1'b0;
            r_dv    <= 1'b0;
            r_ccnt  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (i_cmd.check) begin
                r_issue <= 1'b1;
                r_dv    <= 1'b0;
            end else if (i_cmd.run) begin
                r_issue <= r_issue && (r_rcnt != hi_w);
                r_dv    <= r_issue;
            end else begin
                r_issue <= 1'b0;
                r_dv    <= 1'b0;
            end
            if (i_cmd.clr) begin
                r_ccnt <= clr_last ? '0 : r_ccnt + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= bsc_pkg::t_mode'(i_mode);
            r_idx  <= i_bit_index;
            r_len  <= i_run_length;
        end
        if (i_cmd.check) begin
            r_lo     <= chk_lo;
            r_hi     <= chk_hi;
            r_rcnt   <= CNTW'(chk_lo[SW-1:LSB]);
            r_status <= chk_status;
            r_found  <= '0;
            r_bit    <= 1'b0;
        end else if (i_cmd.run && r_issue) begin
            r_rcnt <= r_rcnt + 1'b1;
        end
        if (i_cmd.run) begin
            r_dcnt <= r_rcnt;
        end
        if (fin) begin
            if (is_test) begin
                r_status <= bsc_pkg::ST_OK;
                r_bit    <= rdata[r_lo[LSB-1:0]];
            end else if (is_write) begin
                r_status <= bsc_pkg::ST_OK;
            end else if (hit) begin
                r_status <= bsc_pkg::ST_OK;
                r_found  <= bsc_pkg::INDEX_W'({r_dcnt, pos});
            end else begin
                r_status <= bsc_pkg::ST_NOT_FOUND;
            end
        end
    end

    assign o_status      = r_status;
    assign o_found_index = r_found;
    assign o_bit_value   = r_bit;

endmodule

/* tb/sv/bitmap_set_clear_find_engine_test.sv */
`timescale 1ns / 1ps

module bitmap_set_clear_find_engine_test;

    localparam int NBITS = bsc_pkg::TOTAL_BITS_DEF;

    typedef struct packed {
        bsc_pkg::t_status status;
        logic [9:0]       found;
        logic             bit_val;
    } t_outcome;

    // cfg rows write the len column into bits_in_use
    typedef struct packed {
        bit               cfg;
        bsc_pkg::t_mode   mode;
        logic [9:0]       idx;
        logic [10:0]      len;
        bit               typed;
        bsc_pkg::t_status status;
        logic [9:0]       found;
        logic             bit_val;
    } t_step;

    typedef struct packed {
        bsc_pkg::t_mode mode;
        logic [9:0]     idx;
        logic [10:0]    len;
    } t_command;

    typedef struct packed {
        int size;
        int idle_pct;
        int items;
    } t_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_mode = '0;
    logic [9:0]  i_bit_index = '0;
    logic [10:0] i_run_length = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [9:0]  o_found_index;
    logic        o_bit_value;

    // typed expectation travels with the command, used instead of the shadow result
    bit          typed_on = 1'b0;
    t_outcome    typed_res = '0;

    logic [NBITS-1:0] shadow_bits = '0;
    logic [10:0]      size_reg = bsc_pkg::BITS_IN_USE_RST;
    t_outcome         pending_q[$];
    int               issued = 0;
    int               retired = 0;
    int               mismatches = 0;

    t_step  plan [0:30];
    t_phase phases [0:6];

    bitmap_set_clear_find_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_bit_index   (i_bit_index),
        .i_run_length  (i_run_length),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_bit_value   (o_bit_value)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int used_bits();
        return (int'(size_reg) < NBITS) ? int'(size_reg) : NBITS;
    endfunction

    // applies one command to the shadow bitmap and returns its result
    function automatic t_outcome apply_command(bsc_pkg::t_mode m, logic [9:0] idx,
                                               logic [10:0] len);
        t_outcome r;
        int       lim;
        int       k;
        r = '{bsc_pkg::ST_OK, 10'd0, 1'b0};
        lim = used_bits();
        case (m)
            bsc_pkg::M_SET, bsc_pkg::M_CLR: begin
                if (int'(idx) >= lim) r.status = bsc_pkg::ST_INVALID;
                else shadow_bits[idx] = (m == bsc_pkg::M_SET);
            end
            bsc_pkg::M_TEST: begin
                if (int'(idx) < lim) r.bit_val = shadow_bits[idx];
            end
            bsc_pkg::M_FIND_CLR, bsc_pkg::M_FIND_SET: begin
                r.status = bsc_pkg::ST_NOT_FOUND;
                // downward scan, last hit is the lowest
                for (k = lim - 1; k >= 0; k--) begin
                    if (shadow_bits[k] == (m == bsc_pkg::M_FIND_SET)) begin
                        r.status = bsc_pkg::ST_OK;
                        r.found = k[9:0];
                    end
                end
            end
            bsc_pkg::M_SET_RUN, bsc_pkg::M_CLR_RUN: begin
                if (int'(idx) + int'(len) > lim) r.status = bsc_pkg::ST_INVALID;
                else for (k = 0; k < int'(len); k++)
                    shadow_bits[int'(idx) + k] = (m == bsc_pkg::M_SET_RUN);
            end
            default: shadow_bits = '0;
        endcase
        return r;
    endfunction

    function automatic t_command pick_command();
        t_command c;
        int       sz;
        int       r;
        sz = used_bits();
        c.mode = bsc_pkg::t_mode'($urandom_range(0, 7));
        c.idx = 10'($urandom_range(0, 1023));
        c.len = 11'($urandom_range(0, 2047));
        if ($urandom_range(0, 99) < 10) return c;   // raw noise
        r = int'($urandom_range(0, 99));
        if (r < 22) c.mode = bsc_pkg::M_SET;
        else if (r < 36) c.mode = bsc_pkg::M_CLR;
        else if (r < 50) c.mode = bsc_pkg::M_TEST;
        else if (r < 62) c.mode = bsc_pkg::M_FIND_CLR;
        else if (r < 74) c.mode = bsc_pkg::M_FIND_SET;
        else if (r < 85) c.mode = bsc_pkg::M_SET_RUN;
        else if (r < 97) c.mode = bsc_pkg::M_CLR_RUN;
        else c.mode = bsc_pkg::M_CLR_ALL;
        if (c.mode inside {bsc_pkg::M_SET, bsc_pkg::M_CLR, bsc_pkg::M_TEST}) begin
            if (sz > 0 && $urandom_range(0, 99) < 95)
                c.idx = 10'($urandom_range(0, sz - 1));
        end else if (c.mode inside {bsc_pkg::M_SET_RUN, bsc_pkg::M_CLR_RUN}) begin
            r = ($urandom_range(0, 99) < 30) ? 0 : int'($urandom_range(0, sz));
            if (r > 1023) r = 1023;
            c.idx = 10'(r);
            if ($urandom_range(0, 99) < 85) begin
                r = sz - int'(c.idx);
                if (r < 0) r = 0;
                if ($urandom_range(0, 99) < 70 && r > 40) r = 40;
                c.len = 11'($urandom_range(0, r));
            end else begin
                c.len = 11'(sz - int'(c.idx) + 1 + int'($urandom_range(0, 3)));
            end
        end
        return c;
    endfunction

    task automatic issue(input bsc_pkg::t_mode m, input logic [9:0] idx,
                         input logic [10:0] len, input bit typed, input t_outcome r);
        start <= 1'b1;
        i_mode <= m;
        i_bit_index <= idx;
        i_run_length <= len;
        typed_on <= typed;
        typed_res <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        issued++;
    endtask

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (retired != issued) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [10:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // scoreboard: results against the oldest expectation, shadow updated on accept
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        if (i_rst_n) begin
            if (o_done) begin
                retired++;
                if (pending_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result with no command pending: %s %0d found %0d bit %0d",
                                 "status", o_status, o_found_index, o_bit_value);
                end else begin
                    want = pending_q.pop_front();
                    if (o_status !== want.status || o_found_index !== want.found ||
                        o_bit_value !== want.bit_val) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected status %0d found %0d bit %0d,",
                                      " got status %0d found %0d bit %0d"},
                                     want.status, want.found, want.bit_val,
                                     o_status, o_found_index, o_bit_value);
                    end
                end
            end
            if (start && !busy) begin
                want = apply_command(bsc_pkg::t_mode'(i_mode), i_bit_index, i_run_length);
                pending_q.push_back(typed_on ? typed_res : want);
            end
            if (i_cfg_valid && o_cfg_ready) size_reg = i_cfg_data;
        end
    end

    initial begin
        t_command c;
        int       p;
        int       n;
        plan = '{
            '{1'b1, bsc_pkg::M_SET,      10'd0,    11'd2047, 1'b0, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_FIND_SET, 10'd0,    11'd0,    1'b1, bsc_pkg::ST_NOT_FOUND,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_FIND_CLR, 10'd0,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_SET,      10'd0,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_SET,      10'd1023, 11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_TEST,     10'd1023, 11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b1},
            '{1'b0, bsc_pkg::M_FIND_SET, 10'd0,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_CLR,      10'd0,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_FIND_SET, 10'd0,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd1023, 1'b0},
            '{1'b0, bsc_pkg::M_SET_RUN,  10'd0,    11'd1024, 1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_FIND_CLR, 10'd0,    11'd0,    1'b1, bsc_pkg::ST_NOT_FOUND,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_SET_RUN,  10'd1,    11'd1024, 1'b1, bsc_pkg::ST_INVALID,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_CLR_RUN,  10'd1023, 11'd2047, 1'b1, bsc_pkg::ST_INVALID,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_CLR_RUN,  10'd700,  11'd300,  1'b0, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_FIND_CLR, 10'd0,    11'd0,    1'b0, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_CLR_RUN,  10'd5,    11'd0,    1'b0, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b1, bsc_pkg::M_SET,      10'd0,    11'd1,    1'b0, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_TEST,     10'd1,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_SET,      10'd1,    11'd0,    1'b1, bsc_pkg::ST_INVALID,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_FIND_CLR, 10'd0,    11'd0,    1'b1, bsc_pkg::ST_NOT_FOUND,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_FIND_SET, 10'd0,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_CLR_ALL,  10'd0,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b1, bsc_pkg::M_SET,      10'd0,    11'd1024, 1'b0, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_TEST,     10'd1023, 11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b1, bsc_pkg::M_SET,      10'd0,    11'd0,    1'b0, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_SET,      10'd0,    11'd0,    1'b1, bsc_pkg::ST_INVALID,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_CLR,      10'd0,    11'd0,    1'b1, bsc_pkg::ST_INVALID,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_TEST,     10'd0,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_FIND_SET, 10'd0,    11'd0,    1'b1, bsc_pkg::ST_NOT_FOUND,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_SET_RUN,  10'd0,    11'd0,    1'b1, bsc_pkg::ST_OK,
              10'd0,    1'b0},
            '{1'b0, bsc_pkg::M_CLR_RUN,  10'd1,    11'd0,    1'b1, bsc_pkg::ST_INVALID,
              10'd0,    1'b0}
        };
        phases = '{
            '{1024, 0,  300},
            '{100,  60, 200},
            '{2047, 14, 250},
            '{517,  60, 200},
            '{1,    0,  50},
            '{33,   14, 100},
            '{1024, 60, 200}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < 31; p++) begin
            if (plan[p].cfg)
                write_size(plan[p].len);
            else
                issue(plan[p].mode, plan[p].idx, plan[p].len, plan[p].typed,
                      '{plan[p].status, plan[p].found, plan[p].bit_val});
        end

        for (p = 0; p < 7; p++) begin
            write_size(phases[p].size[10:0]);
            for (n = 0; n < phases[p].items; n++) begin
                c = pick_command();
                issue(c.mode, c.idx, c.len, 1'b0, '0);
                if (phases[p].idle_pct > 0 && $urandom_range(0, 99) < 2)
                    drain();
                else if ($urandom_range(0, 99) < phases[p].idle_pct)
                    pause(int'($urandom_range(1, 40)));
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && retired == issued && pending_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
